// ----- rtl/core/ihw_pkg.sv -----
// Shared types, register map constants and update functions of the interrupt/halt/wait-state block.
package ihw_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RAISE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_t;

  typedef enum logic [1:0] {
    PWR_RUN  = 2'd0,
    PWR_HALT = 2'd1,
    PWR_STOP = 2'd2
  } power_t;

  // Register map (byte offsets)
  localparam logic [31:0] ADDR_ENABLE   = 32'h0000_0000;
  localparam logic [31:0] ADDR_FLAGS    = 32'h0000_0002;
  localparam logic [31:0] ADDR_WAIT     = 32'h0000_0004;
  localparam logic [31:0] ADDR_MASTER   = 32'h0000_0008;
  localparam logic [31:0] ADDR_POSTBOOT = 32'h0000_0100;
  localparam logic [31:0] ADDR_HALTCTL  = 32'h0000_0101;

  // Memory control sits at 0x800 after a 0x200 bias, mirrored every 64K
  localparam logic [15:0] MC_BIAS   = 16'h0200;
  localparam logic [15:0] MC_TARGET = 16'h0800;
  localparam logic [15:0] MC_OFFSET = MC_TARGET - MC_BIAS;

  localparam logic [15:0] STOP_WAKE_MASK = 16'h3080;
  localparam logic [15:0] HALT_WAKE_MASK = 16'h00FF;

  localparam logic [3:0] SRC_SERIAL = 4'd7;
  localparam logic [3:0] SRC_KEYPAD = 4'd12;
  localparam logic [3:0] SRC_CART   = 4'd13;
  localparam logic [3:0] SRC_LAST   = 4'd13;

  localparam logic [3:0] FIRST_WAIT [4] = '{4'd4, 4'd3, 4'd2, 4'd8};

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  size;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [3:0]  source;
  } req_t;

  typedef struct packed {
    logic [15:0] enable;
    logic [15:0] flags;
    logic        master;
    logic [14:0] wait_ctl;
    logic [7:0]  post_boot;
    logic [31:0] mem_ctl;
    power_t      power;
  } state_t;

  localparam state_t STATE_RESET = '{
    enable:    16'h0000,
    flags:     16'h0000,
    master:    1'b0,
    wait_ctl:  15'h0000,
    post_boot: 8'h00,
    mem_ctl:   32'h0000_0000,
    power:     PWR_RUN
  };

  typedef struct packed {
    logic [31:0] read_data;
    logic        read_hit;
    logic        irq_level;
    logic [1:0]  power_mode;
    logic [14:0] wait_ctl;
  } result_t;

  typedef struct packed {
    logic [3:0] sram_wait;
    logic [3:0] rom0_first_wait;
    logic [1:0] rom0_second_wait;
    logic [3:0] rom1_first_wait;
    logic [2:0] rom1_second_wait;
    logic [3:0] rom2_first_wait;
    logic [3:0] rom2_second_wait;
    logic       prefetch_on;
  } wait_info_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] data;
  } half_rd_t;

  function automatic logic mc_hit(input logic [31:0] a);
    return a[15:2] == MC_OFFSET[15:2];
  endfunction

  function automatic half_rd_t half_read(input state_t s, input logic [31:0] a);
    half_rd_t r;
    r.hit  = 1'b1;
    r.data = 16'h0000;
    if (a == ADDR_ENABLE)        r.data = s.enable;
    else if (a == ADDR_FLAGS)    r.data = s.flags;
    else if (a == ADDR_WAIT)     r.data = {1'b0, s.wait_ctl};
    else if (a == ADDR_MASTER)   r.data = {15'h0000, s.master};
    else if (a == ADDR_POSTBOOT) r.data = 16'h0000;
    else if (mc_hit(a))          r.data = a[1] ? s.mem_ctl[31:16] : s.mem_ctl[15:0];
    else                         r.hit  = 1'b0;
    return r;
  endfunction

  // Halt/stop request: refused while a wake condition is already pending
  function automatic state_t halt_write(input state_t s, input logic [7:0] v);
    state_t      r;
    logic [15:0] act;
    r   = s;
    act = s.enable & s.flags;
    if (v[7]) begin
      if ((act & STOP_WAKE_MASK) == 16'h0000) r.power = PWR_STOP;
    end else if (act == 16'h0000) begin
      r.power = PWR_HALT;
    end
    return r;
  endfunction

  function automatic state_t store_half(input state_t s, input logic [31:0] a,
                                        input logic [15:0] v);
    state_t r;
    r = s;
    if (a == ADDR_ENABLE)      r.enable   = v;
    else if (a == ADDR_FLAGS)  r.flags    = s.flags & ~v;
    else if (a == ADDR_WAIT)   r.wait_ctl = v[14:0];
    else if (a == ADDR_MASTER) r.master   = v[0];
    else if (a == ADDR_POSTBOOT) begin
      r.post_boot = v[7:0];
      r = halt_write(r, v[15:8]);
    end else if (mc_hit(a)) begin
      if (a[1]) r.mem_ctl[31:16] = v;
      else      r.mem_ctl[15:0]  = v;
    end
    return r;
  endfunction

  function automatic state_t raise_source(input state_t s, input logic [3:0] src);
    state_t      r;
    logic [15:0] act;
    r = s;
    if (src <= SRC_LAST) begin
      r.flags = s.flags | (16'h0001 << src);
      act     = s.enable & r.flags;
      if (src == SRC_SERIAL || src == SRC_KEYPAD || src == SRC_CART) begin
        if (s.power == PWR_HALT && (act & HALT_WAKE_MASK) != 16'h0000)
          r.power = PWR_RUN;
        else if (s.power == PWR_STOP && (act & STOP_WAKE_MASK) != 16'h0000)
          r.power = PWR_RUN;
      end else if (s.power == PWR_HALT && act != 16'h0000 && s.master) begin
        r.power = PWR_RUN;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ihw_wait_dec.sv -----
// Decoder from the wait-state control bits to wait counts and prefetch enable.
module ihw_wait_dec (
  input  logic [14:0]             wait_ctl,
  output ihw_pkg::wait_info_t     info
);
  import ihw_pkg::*;

  always_comb begin
    info.sram_wait        = FIRST_WAIT[wait_ctl[1:0]];
    info.rom0_first_wait  = FIRST_WAIT[wait_ctl[3:2]];
    info.rom0_second_wait = wait_ctl[4] ? 2'd1 : 2'd2;
    info.rom1_first_wait  = FIRST_WAIT[wait_ctl[6:5]];
    info.rom1_second_wait = wait_ctl[7] ? 3'd1 : 3'd4;
    info.rom2_first_wait  = FIRST_WAIT[wait_ctl[9:8]];
    info.rom2_second_wait = wait_ctl[10] ? 4'd1 : 4'd8;
    info.prefetch_on      = wait_ctl[14];
  end

endmodule

// ----- rtl/core/ihw_core.sv -----
// Register state, access decode and next-state logic for one request.
module ihw_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  ihw_pkg::req_t     req,
  output ihw_pkg::result_t  result
);
  import ihw_pkg::*;

  state_t      state;
  state_t      state_next;
  half_rd_t    rd_half;
  half_rd_t    rd_lo;
  half_rd_t    rd_hi;
  logic [31:0] byte_base;
  logic [15:0] byte_cur;
  logic [15:0] byte_merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  assign rd_half   = half_read(state, {req.address[31:1], 1'b0});
  assign rd_lo     = half_read(state, {req.address[31:2], 2'b00});
  assign rd_hi     = half_read(state, {req.address[31:2], 2'b10});
  assign byte_base = {req.address[31:1], 1'b0};

  // Byte stores merge with the current halfword; flags merge with zero
  always_comb begin
    if (byte_base == ADDR_ENABLE)      byte_cur = state.enable;
    else if (byte_base == ADDR_WAIT)   byte_cur = {1'b0, state.wait_ctl};
    else if (byte_base == ADDR_MASTER) byte_cur = {15'h0000, state.master};
    else                               byte_cur = 16'h0000;
    byte_merged = req.address[0] ? {req.write_data[7:0], byte_cur[7:0]}
                                 : {byte_cur[15:8], req.write_data[7:0]};
  end

  always_comb begin
    state_next = state;
    unique case (req.func)
      FUNC_WRITE: begin
        unique case (req.size)
          SIZE_BYTE: begin
            if (req.address == ADDR_POSTBOOT) begin
              state_next.post_boot = req.write_data[7:0];
            end else if (req.address == ADDR_HALTCTL) begin
              state_next = halt_write(state, req.write_data[7:0]);
            end else if (mc_hit(req.address)) begin
              state_next.mem_ctl[{req.address[1:0], 3'b000} +: 8] = req.write_data[7:0];
            end else begin
              state_next = store_half(state, byte_base, byte_merged);
            end
          end
          SIZE_HALF: state_next = store_half(state, byte_base, req.write_data[15:0]);
          SIZE_WORD: begin
            state_next = store_half(state, {req.address[31:2], 2'b00},
                                    req.write_data[15:0]);
            state_next = store_half(state_next, {req.address[31:2], 2'b10},
                                    req.write_data[31:16]);
          end
          default: ;
        endcase
      end
      FUNC_RAISE: state_next = raise_source(state, req.source);
      default: ;
    endcase
  end

  always_comb begin
    result.read_data = 32'h0000_0000;
    result.read_hit  = 1'b0;
    if (req.func == FUNC_READ) begin
      unique case (req.size)
        SIZE_BYTE: begin
          if (req.address == ADDR_POSTBOOT) begin
            result.read_data = {24'h000000, state.post_boot};
            result.read_hit  = 1'b1;
          end else if (rd_half.hit) begin
            result.read_data = {24'h000000,
                                req.address[0] ? rd_half.data[15:8] : rd_half.data[7:0]};
            result.read_hit  = 1'b1;
          end
        end
        SIZE_HALF: begin
          if (rd_half.hit) begin
            result.read_data = {16'h0000, rd_half.data};
            result.read_hit  = 1'b1;
          end
        end
        SIZE_WORD: begin
          if (rd_lo.hit) begin
            result.read_data = {rd_hi.hit ? rd_hi.data : 16'h0000, rd_lo.data};
            result.read_hit  = 1'b1;
          end
        end
        default: ;
      endcase
    end
    result.irq_level  = (|(state_next.enable & state_next.flags)) && state_next.master;
    result.power_mode = state_next.power;
    result.wait_ctl   = state_next.wait_ctl;
  end

endmodule

// ----- rtl/core/interrupt_halt_waitstate_regs.sv -----
// Top level of the interrupt, halt/stop and wait-state register block.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------------
//   in      | in_valid/in_ready  | func, size, address, write_data, source
//   out     | out_valid/out_ready| read_data, read_hit, irq_level, power_mode,
//           |                    | sram_wait, rom*_first_wait, rom*_second_wait,
//           |                    | prefetch_on
//
// One request per cycle sustained while out_ready is high; every request yields one
// result, passing through the request register and then the result register.
// The register file is read and updated in a single pass between those two
// registers, so back-to-back requests see each other's effects in order.
// Synchronous reset clears the state and valid registers but not the payloads:
// power state run, all masks, flags and control words zero, both stages empty.
// A stalled result holds the pipeline; in_ready drops only when both the
// request register and the result register are full and out_ready is low.
module interrupt_halt_waitstate_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [1:0]  size,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [3:0]  source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        read_hit,
  output logic        irq_level,
  output logic [1:0]  power_mode,
  output logic [3:0]  sram_wait,
  output logic [3:0]  rom0_first_wait,
  output logic [1:0]  rom0_second_wait,
  output logic [3:0]  rom1_first_wait,
  output logic [2:0]  rom1_second_wait,
  output logic [3:0]  rom2_first_wait,
  output logic [3:0]  rom2_second_wait,
  output logic        prefetch_on
);
  import ihw_pkg::*;

  // request stage
  req_t       req;
  logic       req_valid;
  // result stage
  result_t    res_comb;
  wait_info_t wait_comb;
  result_t    res;
  wait_info_t wait_info;
  logic       advance;

  // the request moves on when the result register is free or being drained
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= '{func: func, size: size, address: address,
               write_data: write_data, source: source};
    end
  end

  ihw_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .result  (res_comb)
  );

  // wait counts decoded from the post-request wait control
  ihw_wait_dec u_wait_dec (
    .wait_ctl (res_comb.wait_ctl),
    .info     (wait_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res       <= res_comb;
      wait_info <= wait_comb;
    end
  end

  assign read_data        = res.read_data;
  assign read_hit         = res.read_hit;
  assign irq_level        = res.irq_level;
  assign power_mode       = res.power_mode;
  assign sram_wait        = wait_info.sram_wait;
  assign rom0_first_wait  = wait_info.rom0_first_wait;
  assign rom0_second_wait = wait_info.rom0_second_wait;
  assign rom1_first_wait  = wait_info.rom1_first_wait;
  assign rom1_second_wait = wait_info.rom1_second_wait;
  assign rom2_first_wait  = wait_info.rom2_first_wait;
  assign rom2_second_wait = wait_info.rom2_second_wait;
  assign prefetch_on      = wait_info.prefetch_on;

endmodule
